// File: rtl/core/tlpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table engine package
// Shared sizes, command codes and derived widths for the page table engine.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    // Number of second-level tables in the on-chip pool (1 to 1024).
    localparam int TABLE_SLOTS       = 16;
    localparam int ENTRIES_PER_LEVEL = 1024;
    localparam int IDX_W             = 10;

    localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
    localparam int POOL_DEPTH = TABLE_SLOTS * ENTRIES_PER_LEVEL;
    localparam int POOL_AW    = SLOT_W + IDX_W;
    localparam int FLAGS_W    = 12;
    localparam int PTE_W      = 32;

    // Directory entry layout: present, flags, slot number.
    localparam int DIR_W = 1 + FLAGS_W + SLOT_W;

    typedef enum logic [1:0] {
        CMD_MAP       = 2'd0,
        CMD_UNMAP     = 2'd1,
        CMD_TRANSLATE = 2'd2,
        CMD_GET_FLAGS = 2'd3
    } t_cmd;

endpackage

// File: rtl/core/tlpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine RAM
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlpt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/two_level_page_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level page table engine
// Map, unmap, translate and get-flags over a 1024-entry directory and a pool
// of second-level tables held in two synchronous RAMs.
// ----------------------------------------------------------------------------
// A map finishes in the directory lookup state; the other commands finish there
// when the directory entry is absent, else go on to the table state (directory
// read, then dependent table read, and for an unmap a table write). A new start
// is only taken in idle; busy stays high until the engine is back in idle. Reset:
// a clearing pass zeroes both RAMs while busy is high. The receiver cannot stall; o_done pulses once.
// ----------------------------------------------------------------------------
module two_level_page_table_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    output logic        o_done,
    output logic [31:0] o_result_addr,
    output logic [11:0] o_result_flags,
    output logic        o_freed_valid,
    output logic [31:0] o_freed_frame,
    output logic        o_status
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_DIR   = 4'b0100,
        ST_TBL   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [tlpt_pkg::POOL_AW-1:0] r_clr_cnt, n_clr_cnt;
    logic [tlpt_pkg::CNT_W-1:0]   r_free_cnt, n_free_cnt;

    // Latched transaction fields.
    tlpt_pkg::t_cmd               r_cmd;
    logic [31:0]                  r_va;
    logic [19:0]                  r_pa_frame;
    logic [11:0]                  r_fl;
    logic [tlpt_pkg::POOL_AW-1:0] r_pool_idx, n_pool_idx;

    // RAM ports.
    logic                          dir_we;
    logic [tlpt_pkg::IDX_W-1:0]    dir_waddr, dir_raddr;
    logic [tlpt_pkg::DIR_W-1:0]    dir_wdata, dir_rdata;
    logic                          pool_we;
    logic [tlpt_pkg::POOL_AW-1:0]  pool_waddr, pool_raddr;
    logic [tlpt_pkg::PTE_W-1:0]    pool_wdata, pool_rdata;

    // Result path.
    logic        done_now;
    logic [31:0] res_addr;
    logic [11:0] res_flags;
    logic        res_freed;
    logic [31:0] res_frame;
    logic        res_status;
    logic        r_done;
    logic [31:0] r_res_addr;
    logic [11:0] r_res_flags;
    logic        r_res_freed;
    logic [31:0] r_res_frame;
    logic        r_res_status;

    logic                         accept;
    logic                         dir_present;
    logic [tlpt_pkg::SLOT_W-1:0]  dir_slot;
    logic [tlpt_pkg::SLOT_W-1:0]  new_slot;
    logic                         pool_full;

    assign accept      = start && (r_state == ST_IDLE);
    assign dir_present = dir_rdata[tlpt_pkg::DIR_W-1];
    assign dir_slot    = dir_rdata[tlpt_pkg::SLOT_W-1:0];
    assign new_slot    = r_free_cnt[tlpt_pkg::SLOT_W-1:0];
    assign pool_full   = (r_free_cnt == tlpt_pkg::CNT_W'(tlpt_pkg::TABLE_SLOTS));

    always_comb begin
        n_state    = r_state;
        n_clr_cnt  = r_clr_cnt;
        n_free_cnt = r_free_cnt;
        n_pool_idx = r_pool_idx;
        dir_we     = 1'b0;
        dir_waddr  = r_va[31:22];
        dir_wdata  = '0;
        dir_raddr  = i_virt_addr[31:22];
        pool_we    = 1'b0;
        pool_waddr = r_pool_idx;
        pool_wdata = '0;
        pool_raddr = r_pool_idx;
        done_now   = 1'b0;
        res_addr   = '0;
        res_flags  = '0;
        res_freed  = 1'b0;
        res_frame  = '0;
        res_status = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                // The directory is swept many times over; the repeats are harmless.
                dir_we     = 1'b1;
                dir_waddr  = r_clr_cnt[tlpt_pkg::IDX_W-1:0];
                pool_we    = 1'b1;
                pool_waddr = r_clr_cnt;
                n_clr_cnt  = r_clr_cnt + 1'b1;
                if (r_clr_cnt == tlpt_pkg::POOL_AW'(tlpt_pkg::POOL_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DIR;
                end
            end
            ST_DIR: begin
                if (r_cmd == tlpt_pkg::CMD_MAP) begin
                    done_now = 1'b1;
                    n_state  = ST_IDLE;
                    if (dir_present) begin
                        pool_we    = 1'b1;
                        pool_waddr = {dir_slot, r_va[21:12]};
                        pool_wdata = {r_pa_frame, r_fl};
                    end else if (pool_full) begin
                        res_status = 1'b1;
                    end else begin
                        dir_we     = 1'b1;
                        dir_wdata  = {1'b1, r_fl | 12'h003, new_slot};
                        pool_we    = 1'b1;
                        pool_waddr = {new_slot, r_va[21:12]};
                        pool_wdata = {r_pa_frame, r_fl};
                        n_free_cnt = r_free_cnt + 1'b1;
                    end
                end else if (!dir_present) begin
                    done_now = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_pool_idx = {dir_slot, r_va[21:12]};
                    pool_raddr = {dir_slot, r_va[21:12]};
                    n_state    = ST_TBL;
                end
            end
            ST_TBL: begin
                done_now = 1'b1;
                n_state  = ST_IDLE;
                case (r_cmd)
                    tlpt_pkg::CMD_UNMAP: begin
                        pool_we = 1'b1;
                        // A frame at or above 1 MiB has a nonzero top 12 bits.
                        if (pool_rdata[0] && (pool_rdata[31:20] != 12'h000)) begin
                            res_freed = 1'b1;
                            res_frame = {pool_rdata[31:12], 12'h000};
                        end
                    end
                    tlpt_pkg::CMD_TRANSLATE: begin
                        if (pool_rdata[0]) begin
                            res_addr = {pool_rdata[31:12], r_va[11:0]};
                        end
                    end
                    tlpt_pkg::CMD_GET_FLAGS: begin
                        res_flags = pool_rdata[11:0];
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_cnt  <= '0;
            r_free_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_cnt  <= n_clr_cnt;
            r_free_cnt <= n_free_cnt;
            r_done     <= done_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= tlpt_pkg::t_cmd'(i_cmd);
            r_va       <= i_virt_addr;
            r_pa_frame <= i_phys_addr[31:12];
            r_fl       <= i_page_flags;
        end
        r_pool_idx <= n_pool_idx;
        if (done_now) begin
            r_res_addr   <= res_addr;
            r_res_flags  <= res_flags;
            r_res_freed  <= res_freed;
            r_res_frame  <= res_frame;
            r_res_status <= res_status;
        end
    end

    tlpt_ram #(
        .DEPTH (tlpt_pkg::ENTRIES_PER_LEVEL),
        .WIDTH (tlpt_pkg::DIR_W),
        .AW    (tlpt_pkg::IDX_W)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (dir_raddr),
        .o_rdata (dir_rdata)
    );

    tlpt_ram #(
        .DEPTH (tlpt_pkg::POOL_DEPTH),
        .WIDTH (tlpt_pkg::PTE_W),
        .AW    (tlpt_pkg::POOL_AW)
    ) u_pool_ram (
        .i_clk   (i_clk),
        .i_we    (pool_we),
        .i_waddr (pool_waddr),
        .i_wdata (pool_wdata),
        .i_raddr (pool_raddr),
        .o_rdata (pool_rdata)
    );

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_result_addr  = r_res_addr;
    assign o_result_flags = r_res_flags;
    assign o_freed_valid  = r_res_freed;
    assign o_freed_frame  = r_res_frame;
    assign o_status       = r_res_status;

    // An accepted transaction always starts with the directory lookup.
    a_accept_to_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_DIR))
        else $error("accepted transaction did not enter directory lookup");

    // The slot counter never runs past the pool size.
    a_free_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= tlpt_pkg::CNT_W'(tlpt_pkg::TABLE_SLOTS))
        else $error("table slot counter overflow");

    // A dropped map is only reported when the pool is exhausted.
    a_status_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> pool_full)
        else $error("map dropped while table slots remain");

    // A result pulse follows directly from a lookup state.
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == ST_DIR || $past(r_state) == ST_TBL))
        else $error("result strobe without a lookup");

    // A released frame is never below the low memory limit.
    a_freed_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_freed_valid) |-> (o_freed_frame[31:20] != 12'h000))
        else $error("low frame reported as released");

endmodule

// File: tb/tlpt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine result checker
// Watches the command and result channels of the page table engine. It keeps
// its own copy of the directory, the slot counter and the table entries,
// predicts the result of every accepted transaction and compares each
// result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tlpt_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [11:0] i_page_flags,
    input  logic        o_done,
    input  logic [31:0] o_result_addr,
    input  logic [11:0] o_result_flags,
    input  logic        o_freed_valid,
    input  logic [31:0] o_freed_frame,
    input  logic        o_status,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          full_drops,
    output int          frames_freed
);

    localparam logic [31:0] LOW_MEMORY_LIMIT = 32'h0010_0000;
    localparam logic [31:0] FRAME_MASK       = 32'hFFFF_F000;

    typedef struct packed {
        logic [31:0] addr;
        logic [11:0] flags;
        logic        freed_valid;
        logic [31:0] freed_frame;
        logic        status;
    } t_walk_result;

    logic                         dir_present [tlpt_pkg::ENTRIES_PER_LEVEL];
    logic [tlpt_pkg::FLAGS_W-1:0] dir_flags   [tlpt_pkg::ENTRIES_PER_LEVEL];
    int unsigned                  dir_slot    [tlpt_pkg::ENTRIES_PER_LEVEL];
    int unsigned                  slots_taken;
    // Only entries written since their slot was allocated are held; any other
    // entry reads as zero.
    logic [tlpt_pkg::PTE_W-1:0]   pte_store [int unsigned];
    t_walk_result                 expected_q [$];
    int                           errors;
    int                           checked;
    int                           drops;
    int                           freed;

    initial begin
        for (int k = 0; k < tlpt_pkg::ENTRIES_PER_LEVEL; k++) begin
            dir_present[k] = 1'b0;
            dir_flags[k]   = '0;
            dir_slot[k]    = 0;
        end
        slots_taken = 0;
        errors      = 0;
        checked     = 0;
        drops       = 0;
        freed       = 0;
    end

    function automatic logic [31:0] read_pte(input int unsigned idx);
        return pte_store.exists(idx) ? pte_store[idx] : 32'h0;
    endfunction

    // Updates the shadow tables for one command and returns its result.
    function automatic t_walk_result apply_command(input tlpt_pkg::t_cmd op,
                                                   input logic [31:0] va,
                                                   input logic [31:0] pa,
                                                   input logic [11:0] fl);
        t_walk_result r;
        int unsigned  d;
        int unsigned  t;
        int unsigned  idx;
        logic [31:0]  pte;
        logic         ok;
        r = '0;
        d = va[31:22];
        t = va[21:12];
        if (op == tlpt_pkg::CMD_MAP) begin
            ok = 1'b1;
            if (!dir_present[d]) begin
                if (slots_taken >= tlpt_pkg::TABLE_SLOTS) begin
                    ok       = 1'b0;
                    r.status = 1'b1;
                    drops++;
                end else begin
                    for (int k = 0; k < tlpt_pkg::ENTRIES_PER_LEVEL; k++)
                        pte_store.delete(slots_taken * tlpt_pkg::ENTRIES_PER_LEVEL + k);
                    dir_present[d] = 1'b1;
                    dir_flags[d]   = fl | 12'h003;
                    dir_slot[d]    = slots_taken;
                    slots_taken++;
                end
            end
            if (ok)
                pte_store[dir_slot[d] * tlpt_pkg::ENTRIES_PER_LEVEL + t] =
                    (pa & FRAME_MASK) | fl;
        end else if (dir_present[d]) begin
            idx = dir_slot[d] * tlpt_pkg::ENTRIES_PER_LEVEL + t;
            pte = read_pte(idx);
            case (op)
                tlpt_pkg::CMD_UNMAP: begin
                    pte_store[idx] = 32'h0;
                    if (pte[0] && (pte & FRAME_MASK) >= LOW_MEMORY_LIMIT) begin
                        r.freed_valid = 1'b1;
                        r.freed_frame = pte & FRAME_MASK;
                        freed++;
                    end
                end
                tlpt_pkg::CMD_TRANSLATE: begin
                    if (pte[0])
                        r.addr = (pte & FRAME_MASK) | {20'h0, va[11:0]};
                end
                default: begin
                    r.flags = pte[11:0];
                end
            endcase
        end
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_walk_result want;
        if (i_rst_n) begin
            if (start && !busy)
                expected_q.push_back(apply_command(tlpt_pkg::t_cmd'(i_cmd), i_virt_addr,
                                                   i_phys_addr, i_page_flags));
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual addr 0x%08h",
                             $time, o_result_addr);
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    compare_field("result_addr", want.addr, o_result_addr);
                    compare_field("result_flags", {20'h0, want.flags}, {20'h0, o_result_flags});
                    compare_field("freed_valid", {31'h0, want.freed_valid},
                                  {31'h0, o_freed_valid});
                    compare_field("freed_frame", want.freed_frame, o_freed_frame);
                    compare_field("status", {31'h0, want.status}, {31'h0, o_status});
                end
            end
        end
        fail_count      <= errors;
        pending         <= expected_q.size();
        results_checked <= checked;
        full_drops      <= drops;
        frames_freed    <= freed;
    end

endmodule

// File: tb/tb_two_level_page_table_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table engine testbench
// Drives directed and random map, unmap, translate and get-flags commands
// through the start/busy handshake under several sender pacing phases. The
// result checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_two_level_page_table_engine;

    // Clearing pass after reset plus generous room for every command.
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int DRAIN_CYCLES     = 16;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  i_cmd        = tlpt_pkg::CMD_MAP;
    logic [31:0] i_virt_addr  = '0;
    logic [31:0] i_phys_addr  = '0;
    logic [11:0] i_page_flags = '0;
    logic        busy;
    logic        o_done;
    logic [31:0] o_result_addr;
    logic [11:0] o_result_flags;
    logic        o_freed_valid;
    logic [31:0] o_freed_frame;
    logic        o_status;

    int fail_count;
    int pending;
    int results_checked;
    int full_drops;
    int frames_freed;
    int cycles = 0;
    int idle_pct = 0;
    int issued = 0;
    int directed_count = 0;

    logic [9:0] dir_pick [24];
    logic [9:0] tix_pick [8];

    two_level_page_table_engine uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_virt_addr    (i_virt_addr),
        .i_phys_addr    (i_phys_addr),
        .i_page_flags   (i_page_flags),
        .o_done         (o_done),
        .o_result_addr  (o_result_addr),
        .o_result_flags (o_result_flags),
        .o_freed_valid  (o_freed_valid),
        .o_freed_frame  (o_freed_frame),
        .o_status       (o_status)
    );

    tlpt_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_virt_addr     (i_virt_addr),
        .i_phys_addr     (i_phys_addr),
        .i_page_flags    (i_page_flags),
        .o_done          (o_done),
        .o_result_addr   (o_result_addr),
        .o_result_flags  (o_result_flags),
        .o_freed_valid   (o_freed_valid),
        .o_freed_frame   (o_freed_frame),
        .o_status        (o_status),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .full_drops      (full_drops),
        .frames_freed    (frames_freed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
            $display("tb_two_level_page_table_engine: errors");
            $finish;
        end
    end

    // Returns once busy is seen low again after the command has been presented;
    // start stays high so a following command can go out back to back.
    task automatic issue_command(input tlpt_pkg::t_cmd op, input logic [31:0] va,
                                 input logic [31:0] pa, input logic [11:0] fl);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cmd        <= op;
        i_virt_addr  <= va;
        i_phys_addr  <= pa;
        i_page_flags <= fl;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        issued++;
    endtask

    // Addresses mostly land on a small set of directory and table indexes so
    // that lookups find mapped entries and the table pool runs out early.
    task automatic issue_random_command();
        int unsigned    roll;
        tlpt_pkg::t_cmd op;
        logic [9:0]     d;
        logic [9:0]     t;
        logic [31:0]    noise;
        logic [31:0]    pa;
        logic [11:0]    fl;
        roll  = $urandom_range(99);
        op    = (roll < 35) ? tlpt_pkg::CMD_MAP : (roll < 55) ? tlpt_pkg::CMD_UNMAP :
                (roll < 80) ? tlpt_pkg::CMD_TRANSLATE : tlpt_pkg::CMD_GET_FLAGS;
        d     = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) :
                                           dir_pick[$urandom_range(23)];
        t     = ($urandom_range(9) == 0) ? 10'($urandom_range(1023)) :
                                           tix_pick[$urandom_range(7)];
        noise = $urandom;
        pa    = $urandom;
        if ($urandom_range(99) < 30)
            pa[31:20] = '0;
        fl = noise[31:20];
        if ($urandom_range(99) < 75)
            fl[0] = 1'b1;
        issue_command(op, {d, t, noise[11:0]}, pa, fl);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands: field extremes, low and high frames, non-present
        // entries, absent directory entries and never-written table entries.
        issue_command(tlpt_pkg::CMD_MAP,       32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
        issue_command(tlpt_pkg::CMD_TRANSLATE, 32'h0000_0ABC, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_GET_FLAGS, 32'h0000_0000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_MAP,       32'h0000_1000, 32'h000F_F000, 12'h001);
        issue_command(tlpt_pkg::CMD_UNMAP,     32'h0000_1000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_MAP,       32'h0000_2000, 32'h0010_0FFF, 12'h001);
        issue_command(tlpt_pkg::CMD_UNMAP,     32'h0000_2123, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_UNMAP,     32'h0000_0000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_TRANSLATE, 32'h0000_0FFF, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_MAP,       32'hFFFF_FFFF, 32'h0,         12'h000);
        issue_command(tlpt_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_GET_FLAGS, 32'hFFFF_FFFF, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_UNMAP,     32'hFFFF_FFFF, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_MAP,       32'h0000_3000, 32'h1234_5000, 12'hFFE);
        issue_command(tlpt_pkg::CMD_UNMAP,     32'h0000_3000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_UNMAP,     32'h0040_0000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_TRANSLATE, 32'h0040_0000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_GET_FLAGS, 32'h0040_0000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_TRANSLATE, 32'h0000_4000, 32'h0,         12'h0);
        issue_command(tlpt_pkg::CMD_GET_FLAGS, 32'h003F_F000, 32'h0,         12'h0);
        directed_count = issued;

        dir_pick[0] = 10'd0;
        dir_pick[1] = 10'd1023;
        for (int k = 2; k < 24; k++)
            dir_pick[k] = 10'($urandom_range(1023));
        for (int k = 0; k < 8; k++)
            tix_pick[k] = 10'($urandom_range(1023));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       idle_pct = 0;
                1:       idle_pct = 58;
                2:       idle_pct = 27;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                issue_random_command();
        end
        start <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Issued %0d commands (%0d directed, the rest random over four pacing phases),",
                 issued, directed_count);
        $display("checked %0d results; %0d maps found the pool full, %0d unmaps freed a frame.",
                 results_checked, full_drops, frames_freed);
        if (fail_count == 0) begin
            $display("tb_two_level_page_table_engine: clean");
        end else begin
            $display("tb_two_level_page_table_engine: errors");
        end
        $finish;
    end

endmodule
